// ----- design/tcw_pkg.sv -----
`timescale 1ns / 1ps
// tcw_pkg: shared types and fixed constants of the text console writer
// no dependencies

package tcw_pkg;

	localparam int ACTION_W = 2;
	localparam int CHAR_W   = 8;
	localparam int TCOL_W   = 7;
	localparam int TROW_W   = 5;
	localparam int LIN_W    = 11;

	localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

	localparam logic [CHAR_W-1:0] RESET_ATTR = 8'd15;

	typedef struct packed {
		logic [CHAR_W-1:0] attr;
		logic [CHAR_W-1:0] code;
	} cell_t;

endpackage

// ----- design/tcw_ifs.sv -----
`timescale 1ns / 1ps
// tcw_cmd_if / tcw_rsp_if: valid/ready channels of the text console writer
// depends on tcw_pkg for field widths

interface tcw_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [tcw_pkg::ACTION_W-1:0]     action;
	logic [tcw_pkg::CHAR_W-1:0]       char_code;
	logic [tcw_pkg::TCOL_W-1:0]       target_col;
	logic [tcw_pkg::TROW_W-1:0]       target_row;

	modport source (output valid, action, char_code, target_col, target_row, input ready);
	modport sink (input valid, action, char_code, target_col, target_row, output ready);
endinterface

interface tcw_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [tcw_pkg::TCOL_W-1:0]       cur_col;
	logic [tcw_pkg::TROW_W-1:0]       cur_row;
	logic [tcw_pkg::LIN_W-1:0]        cur_linear;
	logic [tcw_pkg::CHAR_W-1:0]       cell_char;
	logic [tcw_pkg::CHAR_W-1:0]       cell_attr;

	modport source (output valid, cur_col, cur_row, cur_linear, cell_char, cell_attr,
		input ready);
	modport sink (input valid, cur_col, cur_row, cur_linear, cell_char, cell_attr,
		output ready);
endinterface

// ----- design/text_console_writer.sv -----
`timescale 1ns / 1ps
// Text console writer: COLUMNS x ROWS cell screen held in one synchronous RAM,
// with cursor control, put-character handling, scrolling and clearing.
// One command is handled at a time on a single-write, single-read RAM port
// pair. A tab writes up to TAB_WIDTH blanks (one RAM write per blank). A
// scroll copies one cell per cycle, then fills the bottom row. After reset
// the RAM is blanked before the first command beat is taken; text_color
// writes are taken during that pass. A finished result waits in an output
// register while the next command beat is taken.
// depends on tcw_pkg and tcw_ifs

module text_console_writer #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcw_pkg::CHAR_W-1:0]     cfg_wdata,
	tcw_cmd_if.sink                        cmd,
	tcw_rsp_if.source                      rsp
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int TW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
	localparam logic [TW-1:0] TAB_LAST  = TW'(TAB_WIDTH - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PUT   = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_FILL  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                    state_q;
	logic [CW-1:0]                 col_q;
	logic [RW-1:0]                 row_q;
	logic [AW-1:0]                 ptr_q;
	logic [TW-1:0]                 tab_q;
	logic [tcw_pkg::CHAR_W-1:0]    char_q;
	logic [tcw_pkg::CHAR_W-1:0]    color_q;
	logic [tcw_pkg::CHAR_W-1:0]    fill_attr_q;
	logic                          init_q;
	tcw_pkg::cell_t                cell_q;
	tcw_pkg::cell_t                rd_q;
	logic                          copy_s1;
	logic [AW-1:0]                 copy_addr_s1;

	logic                          rsp_valid_q;
	logic [tcw_pkg::TCOL_W-1:0]    rsp_col_q;
	logic [tcw_pkg::TROW_W-1:0]    rsp_row_q;
	logic [tcw_pkg::LIN_W-1:0]     rsp_lin_q;
	tcw_pkg::cell_t                rsp_cell_q;

	logic [CW-1:0]                 sat_col;
	logic [RW-1:0]                 sat_row;
	logic [CW-1:0]                 bs_col;
	logic [RW-1:0]                 bs_row;
	logic [CW-1:0]                 pos_col;
	logic [RW-1:0]                 pos_row;
	logic [AW-1:0]                 lin;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	tcw_pkg::cell_t                mem_wdata;
	logic [AW-1:0]                 mem_raddr;
	tcw_pkg::cell_t                cells_mem [CELLS];

	// target saturated to the grid
	assign sat_col = (int'(cmd.target_col) > COLUMNS - 1) ? COL_LAST : CW'(cmd.target_col);
	assign sat_row = (int'(cmd.target_row) > ROWS - 1) ? ROW_LAST : RW'(cmd.target_row);

	// backspace position
	always_comb begin
		bs_col = col_q;
		bs_row = row_q;
		if (col_q != '0) begin
			bs_col = col_q - 1'b1;
		end else if (row_q != '0) begin
			bs_row = row_q - 1'b1;
			bs_col = COL_LAST;
		end
	end

	always_comb begin
		pos_col = col_q;
		pos_row = row_q;
		case (state_q)
			ST_IDLE: begin
				pos_col = sat_col;
				pos_row = sat_row;
			end
			ST_PUT: begin
				if (char_q == tcw_pkg::CH_BACKSPACE) begin
					pos_col = bs_col;
					pos_row = bs_row;
				end
			end
			default: begin
			end
		endcase
	end

	assign lin = AW'(int'(pos_row) * COLUMNS + int'(pos_col));

	// ram port control
	always_comb begin
		mem_we         = 1'b0;
		mem_waddr      = lin;
		mem_wdata.attr = color_q;
		mem_wdata.code = tcw_pkg::CH_BLANK;
		if (copy_s1) begin
			mem_we    = 1'b1;
			mem_waddr = copy_addr_s1;
			mem_wdata = rd_q;
		end else begin
			case (state_q)
				ST_PUT: begin
					if (char_q != tcw_pkg::CH_NEWLINE) begin
						mem_we = 1'b1;
						if (char_q != tcw_pkg::CH_BACKSPACE && char_q != tcw_pkg::CH_TAB) begin
							mem_wdata.code = char_q;
						end
					end
				end
				ST_FILL: begin
					mem_we         = 1'b1;
					mem_waddr      = ptr_q;
					mem_wdata.attr = fill_attr_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign mem_raddr = (state_q == ST_COPY) ? ptr_q + ROW_STEP : lin;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cells_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= cells_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			tab_q       <= '0;
			char_q      <= '0;
			color_q     <= tcw_pkg::RESET_ATTR;
			fill_attr_q <= tcw_pkg::RESET_ATTR;
			init_q      <= 1'b1;
			cell_q      <= '0;
			copy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_col_q   <= '0;
			rsp_row_q   <= '0;
			rsp_lin_q   <= '0;
			rsp_cell_q  <= '0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			copy_s1 <= (state_q == ST_COPY);
			if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						char_q <= cmd.char_code;
						tab_q  <= '0;
						cell_q <= '0;
						case (cmd.action)
							tcw_pkg::ACT_PUT: begin
								state_q <= ST_PUT;
							end
							tcw_pkg::ACT_SET: begin
								col_q   <= sat_col;
								row_q   <= sat_row;
								state_q <= ST_DONE;
							end
							tcw_pkg::ACT_CLEAR: begin
								col_q       <= '0;
								row_q       <= '0;
								ptr_q       <= '0;
								fill_attr_q <= color_q;
								state_q     <= ST_FILL;
							end
							tcw_pkg::ACT_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					cell_q  <= rd_q;
					state_q <= ST_DONE;
				end
				ST_PUT: begin
					if (char_q == tcw_pkg::CH_NEWLINE) begin
						col_q <= '0;
						if (row_q == ROW_LAST) begin
							ptr_q       <= '0;
							fill_attr_q <= color_q;
							state_q     <= ST_COPY;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_DONE;
						end
					end else if (char_q == tcw_pkg::CH_BACKSPACE) begin
						col_q   <= bs_col;
						row_q   <= bs_row;
						state_q <= ST_DONE;
					end else if (col_q == COL_LAST) begin
						col_q <= '0;
						if (row_q == ROW_LAST) begin
							ptr_q       <= '0;
							fill_attr_q <= color_q;
							state_q     <= ST_COPY;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_DONE;
						end
					end else begin
						col_q <= col_q + 1'b1;
						tab_q <= tab_q + 1'b1;
						if (char_q != tcw_pkg::CH_TAB || tab_q == TAB_LAST) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_COPY: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == COPY_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == CELL_LAST) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_col_q   <= tcw_pkg::TCOL_W'(col_q);
						rsp_row_q   <= tcw_pkg::TROW_W'(row_q);
						rsp_lin_q   <= tcw_pkg::LIN_W'(lin);
						rsp_cell_q  <= cell_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.cur_col    = rsp_col_q;
	assign rsp.cur_row    = rsp_row_q;
	assign rsp.cur_linear = rsp_lin_q;
	assign rsp.cell_char  = rsp_cell_q.code;
	assign rsp.cell_attr  = rsp_cell_q.attr;

endmodule

// ----- design/tcw_checker.sv -----
`timescale 1ns / 1ps
// tcw_assertions: port-level assertions for text_console_writer, with its bind
// depends on tcw_pkg

module tcw_assertions #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [tcw_pkg::TCOL_W-1:0]     cur_col,
	input logic [tcw_pkg::TROW_W-1:0]     cur_row,
	input logic [tcw_pkg::LIN_W-1:0]      cur_linear,
	input logic [tcw_pkg::CHAR_W-1:0]     cell_char,
	input logic [tcw_pkg::CHAR_W-1:0]     cell_attr
);

	localparam bit NARROW = (COLUMNS <= 128) && (ROWS <= 32);

	// one beat in, then busy until the result is formed
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken on consecutive cycles");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cur_col) && $stable(cur_row)
			&& $stable(cur_linear) && $stable(cell_char) && $stable(cell_attr))
		else $error("stalled result beat changed");

	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW |-> int'(cur_col) < COLUMNS && int'(cur_row) < ROWS)
		else $error("cursor outside the grid");

	a_linear_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && NARROW |->
			cur_linear == tcw_pkg::LIN_W'(int'(cur_row) * COLUMNS + int'(cur_col)))
		else $error("linear cursor address mismatch");

endmodule

bind text_console_writer tcw_assertions #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_assertions (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.cur_col    (rsp.cur_col),
	.cur_row    (rsp.cur_row),
	.cur_linear (rsp.cur_linear),
	.cell_char  (rsp.cell_char),
	.cell_attr  (rsp.cell_attr)
);
